// ===== hdl/hss_pkg.sv =====
// Package for the heat stencil step block: sizes, coefficient and value types,
// the job handed from the front end to the arithmetic back end, and helpers.
// Used by every other file of the block; depends on nothing.
package hss_pkg;

  // Grid and number format.
  localparam int MAX_ROWS    = 256;
  localparam int MAX_COLS    = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int DIM_W       = $clog2((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1;
  localparam int MIN_DIM     = 3;
  localparam int COEFF_W     = 16;
  localparam int FRAC_BITS   = 16;

  // Stencil arithmetic widths: a second difference needs three extra bits,
  // the product adds the coefficient and its zero sign bit.
  localparam int DIFF_W = VALUE_WIDTH + 3;
  localparam int PROD_W = DIFF_W + COEFF_W + 1;
  localparam int SUM_W  = DIFF_W + 2;

  // Job queue between the front end and the back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  localparam value_t VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEFF_X   = 2'd0,
    CFG_COEFF_Y   = 2'd1,
    CFG_ROWS_USED = 2'd2,
    CFG_COLS_USED = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic [COEFF_W-1:0] coeff_x;
    logic [COEFF_W-1:0] coeff_y;
    logic [DIM_W-1:0]   rows_used;
    logic [DIM_W-1:0]   cols_used;
  } cfg_t;

  // One point update with all five neighbors already fetched.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             is_edge;     // first result is the row's boundary value
    logic             has_second;  // a boundary result for the last column follows
    logic             last;        // the second result closes the sweep
    value_t           edge_val;
    value_t           up;
    value_t           down;
    value_t           mid;
    value_t           left;
    value_t           right;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Geometry registers act as at least three and at most the store size.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    clamp_dim = v;
    if (v < DIM_W'(MIN_DIM)) begin
      clamp_dim = DIM_W'(MIN_DIM);
    end else if (v > maxv) begin
      clamp_dim = maxv;
    end
  endfunction

endpackage

// ===== hdl/hss_stream_if.sv =====
// Handshake channels of the heat stencil step block: the sample item channel
// and the result item channel. Depends on hss_pkg for the payload types.
interface hss_item_if;
  import hss_pkg::*;

  logic   valid;
  logic   ready;
  value_t sample;
  value_t edge_value;
  logic   start_of_grid;

  modport source (output valid, sample, edge_value, start_of_grid, input ready);
  modport sink   (input valid, sample, edge_value, start_of_grid, output ready);
endinterface

interface hss_result_if;
  import hss_pkg::*;

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  value_t           value;
  logic             last_of_grid;

  modport source (output valid, row, col, value, last_of_grid, input ready);
  modport sink   (input valid, row, col, value, last_of_grid, output ready);
endinterface

// ===== hdl/hss_front.sv =====
// Front end of the heat stencil step: accepts sample items, tracks the raster
// position, owns the two line stores and builds one job per emitting item.
// Depends on hss_pkg and hss_item_if.
module hss_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hss_pkg::cfg_t  cfg_i,
  hss_item_if.sink       items_i,
  input  hss_pkg::q_stat_t q_stat_i,
  output logic           push_o,
  output hss_pkg::job_t  job_o
);
  import hss_pkg::*;

  logic [DIM_W-1:0] rows, cols;
  logic [DIM_W-1:0] r_base, c_base, r_pos, c_pos, r_next, c_next;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] r8;
  logic [COL_W-1:0] c8;
  logic             accept;
  logic             col_first, last_col, has_job;

  logic             pend_q, pend_par_q;
  logic [COL_W-1:0] pend_col_q;
  value_t           edge_cur_q, edge_prev_q, prev_sample_q;

  logic             wen, wpar;
  logic [COL_W-1:0] waddr, cur_addr, oth_addr, addr_u, addr_m;
  value_t           line_upper  [MAX_COLS];
  value_t           line_middle [MAX_COLS];
  value_t           rd_u_q, rd_m_q, cur_rd, oth_rd;
  logic             rd_par_q;
  value_t           mid_q, left_q;

  logic             s1_valid_q;
  logic [ROW_W-1:0] s1_row_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_is_edge_q, s1_second_q, s1_last_q;
  value_t           s1_edge_q, s1_down_q;

  assign rows = clamp_dim(cfg_i.rows_used, DIM_W'(MAX_ROWS));
  assign cols = clamp_dim(cfg_i.cols_used, DIM_W'(MAX_COLS));

  // Position of this item and of the next one, with wrap to the next row
  // and to the top of the grid.
  always_comb begin
    c_base = items_i.start_of_grid ? '0 : DIM_W'(col_q);
    r_base = items_i.start_of_grid ? '0 : DIM_W'(row_q);
    c_pos  = c_base;
    r_pos  = r_base;
    if (c_base >= cols) begin
      c_pos = '0;
      r_pos = r_base + DIM_W'(1);
    end
    if (r_pos >= rows) begin
      r_pos = '0;
    end
    c_next = c_pos + DIM_W'(1);
    r_next = r_pos;
    if (c_next >= cols) begin
      c_next = '0;
      r_next = r_pos + DIM_W'(1);
    end
    if (r_next >= rows) begin
      r_next = '0;
    end
  end

  assign r8        = r_pos[ROW_W-1:0];
  assign c8        = c_pos[COL_W-1:0];
  assign col_first = (c_pos == '0);
  assign last_col  = (c_pos == cols - DIM_W'(1));
  assign has_job   = (r_pos >= DIM_W'(2)) && !col_first;

  // A new item enters when the job stage is empty or drains into the queue.
  assign push_o        = s1_valid_q && !q_stat_i.full;
  assign items_i.ready = !s1_valid_q || !q_stat_i.full;
  assign accept        = items_i.valid && items_i.ready;

  // The previous sample goes into the current row's store one column back;
  // at column 0 the held last-column sample of the previous row is written.
  assign wen      = !col_first || pend_q;
  assign waddr    = col_first ? pend_col_q : (c8 - COL_W'(1));
  assign wpar     = col_first ? pend_par_q : r8[0];
  assign cur_addr = c8 - COL_W'(1);
  assign oth_addr = c8;
  assign addr_u   = r8[0] ? oth_addr : cur_addr;
  assign addr_m   = r8[0] ? cur_addr : oth_addr;

  // Even rows live in the upper store, odd rows in the middle store.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (wen && !wpar) begin
        line_upper[waddr] <= prev_sample_q;
      end
      rd_u_q <= line_upper[addr_u];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (wen && wpar) begin
        line_middle[waddr] <= prev_sample_q;
      end
      rd_m_q <= line_middle[addr_m];
    end
  end

  assign cur_rd = rd_par_q ? rd_m_q : rd_u_q;
  assign oth_rd = rd_par_q ? rd_u_q : rd_m_q;

  // Position, boundary values and the held write of the last column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q         <= '0;
      col_q         <= '0;
      pend_q        <= 1'b0;
      pend_par_q    <= 1'b0;
      pend_col_q    <= '0;
      edge_cur_q    <= '0;
      edge_prev_q   <= '0;
      prev_sample_q <= '0;
      rd_par_q      <= 1'b0;
      s1_valid_q    <= 1'b0;
    end else begin
      if (accept) begin
        row_q         <= r_next[ROW_W-1:0];
        col_q         <= c_next[COL_W-1:0];
        pend_q        <= last_col;
        pend_par_q    <= r8[0];
        pend_col_q    <= c8;
        prev_sample_q <= items_i.sample;
        rd_par_q      <= r8[0];
        if (col_first) begin
          edge_prev_q <= edge_cur_q;
          edge_cur_q  <= items_i.edge_value;
        end
      end
      if (accept) begin
        s1_valid_q <= has_job;
      end else if (push_o) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Job stage: the row above arrives from the store's read register, loaded on
  // accept; the row in the middle slides through a three-column window.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      left_q       <= mid_q;
      mid_q        <= oth_rd;
      s1_row_q     <= r8 - ROW_W'(1);
      s1_col_q     <= c8 - COL_W'(1);
      s1_is_edge_q <= (c_pos == DIM_W'(1));
      s1_second_q  <= last_col;
      s1_last_q    <= (r_pos == rows - DIM_W'(1));
      s1_edge_q    <= edge_prev_q;
      s1_down_q    <= prev_sample_q;
    end
  end

  always_comb begin
    job_o            = '0;
    job_o.row        = s1_row_q;
    job_o.col        = s1_col_q;
    job_o.is_edge    = s1_is_edge_q;
    job_o.has_second = s1_second_q;
    job_o.last       = s1_last_q;
    job_o.edge_val   = s1_edge_q;
    job_o.up         = cur_rd;
    job_o.down       = s1_down_q;
    job_o.mid        = mid_q;
    job_o.left       = left_q;
    job_o.right      = oth_rd;
  end

endmodule

// ===== hdl/hss_queue.sv =====
// Short job queue between the front end and the back end of the heat stencil
// step, so that each side can stall on its own. Depends on hss_pkg.
module hss_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hss_pkg::job_t     job_i,
  input  logic              pop_i,
  output hss_pkg::job_t     job_o,
  output hss_pkg::q_stat_t  stat_o
);
  import hss_pkg::*;

  job_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign stat_o.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign job_o        = slot_q[rd_ptr_q];

  // Storage is written only at the write pointer.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
        2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== hdl/hss_back.sv =====
// Back end of the heat stencil step: second differences, coefficient products,
// saturating sum and the result register with its second boundary item.
// Depends on hss_pkg and hss_result_if.
module hss_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hss_pkg::cfg_t     cfg_i,
  input  hss_pkg::job_t     job_i,
  input  hss_pkg::q_stat_t  q_stat_i,
  output logic              pop_o,
  hss_result_if.source      results_o
);
  import hss_pkg::*;

  logic a_free, b_free, c_free, a_take, b_take, c_take, out_fire;

  logic             a_valid_q, a_is_edge_q, a_second_q, a_last_q;
  logic [ROW_W-1:0] a_row_q;
  logic [COL_W-1:0] a_col_q;
  value_t           a_edge_q, a_mid_q;
  diff_t            a_dy_q, a_dx_q;

  logic             b_valid_q, b_is_edge_q, b_second_q, b_last_q;
  logic [ROW_W-1:0] b_row_q;
  logic [COL_W-1:0] b_col_q;
  value_t           b_edge_q, b_mid_q;
  diff_t            b_px_q, b_py_q;

  logic signed [COEFF_W:0] coeff_x_s, coeff_y_s;
  prod_t                   px, py;
  sum_t                    sum;
  value_t                  sat;

  logic             out_valid_q, out_last_q, second_q, sec_last_q;
  logic [ROW_W-1:0] out_row_q;
  logic [COL_W-1:0] out_col_q, sec_col_q;
  value_t           out_value_q, sec_value_q;

  // Stage handshakes: the result register frees up once its item is taken
  // and no boundary item of the same job is still to go.
  assign out_fire = out_valid_q && results_o.ready;
  assign c_free   = !out_valid_q || (results_o.ready && !second_q);
  assign c_take   = b_valid_q && c_free;
  assign b_free   = !b_valid_q || c_take;
  assign b_take   = a_valid_q && b_free;
  assign a_free   = !a_valid_q || b_take;
  assign pop_o    = !q_stat_i.empty && a_free;
  assign a_take   = pop_o;

  // Multipliers see the coefficients as positive fractions.
  assign coeff_x_s = signed'({1'b0, cfg_i.coeff_x});
  assign coeff_y_s = signed'({1'b0, cfg_i.coeff_y});
  assign px        = a_dy_q * coeff_x_s;
  assign py        = a_dx_q * coeff_y_s;

  // Sum of the center and both floored products, clipped to the value range.
  always_comb begin
    sum = sum_t'(b_mid_q) + sum_t'(b_px_q) + sum_t'(b_py_q);
    sat = b_mid_q;
    if (sum > sum_t'(VALUE_MAX)) begin
      sat = VALUE_MAX;
    end else if (sum < sum_t'(VALUE_MIN)) begin
      sat = VALUE_MIN;
    end else begin
      sat = sum[VALUE_WIDTH-1:0];
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      if (a_take) begin
        a_valid_q <= 1'b1;
      end else if (b_take) begin
        a_valid_q <= 1'b0;
      end
      if (b_take) begin
        b_valid_q <= 1'b1;
      end else if (c_take) begin
        b_valid_q <= 1'b0;
      end
      if (c_take) begin
        out_valid_q <= 1'b1;
        second_q    <= b_second_q;
      end else if (out_fire) begin
        out_valid_q <= second_q;
        second_q    <= 1'b0;
      end
    end
  end

  // Stage A: second differences along the column and along the row.
  always_ff @(posedge clk_i) begin
    if (a_take) begin
      a_row_q     <= job_i.row;
      a_col_q     <= job_i.col;
      a_is_edge_q <= job_i.is_edge;
      a_second_q  <= job_i.has_second;
      a_last_q    <= job_i.last;
      a_edge_q    <= job_i.edge_val;
      a_mid_q     <= job_i.mid;
      a_dy_q      <= diff_t'(job_i.up) + diff_t'(job_i.down) - (diff_t'(job_i.mid) <<< 1);
      a_dx_q      <= diff_t'(job_i.left) + diff_t'(job_i.right) - (diff_t'(job_i.mid) <<< 1);
    end
  end

  // Stage B: products, rounded toward minus infinity by dropping the fraction.
  always_ff @(posedge clk_i) begin
    if (b_take) begin
      b_row_q     <= a_row_q;
      b_col_q     <= a_col_q;
      b_is_edge_q <= a_is_edge_q;
      b_second_q  <= a_second_q;
      b_last_q    <= a_last_q;
      b_edge_q    <= a_edge_q;
      b_mid_q     <= a_mid_q;
      b_px_q      <= px[FRAC_BITS+DIFF_W-1:FRAC_BITS];
      b_py_q      <= py[FRAC_BITS+DIFF_W-1:FRAC_BITS];
    end
  end

  // Result register; the last-column boundary item of a job follows its
  // first item from a held copy.
  always_ff @(posedge clk_i) begin
    if (c_take) begin
      out_row_q   <= b_row_q;
      out_col_q   <= b_col_q;
      out_value_q <= b_is_edge_q ? b_edge_q : sat;
      out_last_q  <= 1'b0;
      sec_col_q   <= b_col_q + COL_W'(1);
      sec_value_q <= b_edge_q;
      sec_last_q  <= b_last_q;
    end else if (out_fire && second_q) begin
      out_col_q   <= sec_col_q;
      out_value_q <= sec_value_q;
      out_last_q  <= sec_last_q;
    end
  end

  assign results_o.valid        = out_valid_q;
  assign results_o.row          = out_row_q;
  assign results_o.col          = out_col_q;
  assign results_o.value        = out_value_q;
  assign results_o.last_of_grid = out_last_q;

endmodule

// ===== hdl/heat_stencil_step.sv =====
// Top level of the heat stencil step: configuration registers, front end,
// job queue and arithmetic back end. Depends on hss_pkg, the channel
// interfaces, hss_front, hss_queue and hss_back.
//
//   channel    direction  handshake          payload
//   items_i    in         valid / ready      sample, edge_value, start_of_grid
//   results_o  out        valid / ready      row, col, value, last_of_grid
//   cfg        in         cfg_we_i only      cfg_index_i, cfg_data_i
//
// One sample item is taken per clock unless the job stage and queue are full;
// the line stores are read and written once per item, and each item emits at
// most one job into a four-entry queue. A result is offered once its item has
// passed store read, queue, differences and products, then the saturating sum
// in the result register. A last-column item yields two results, sent one
// after the other; the row's first column yields none, so the rates even out.
// Reset clears position, boundary values and all valid bits; the line stores
// hold nothing defined until a sweep has written them and need no clearing.
module heat_stencil_step (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [hss_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [hss_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  hss_item_if.sink                           items_i,
  hss_result_if.source                       results_o
);
  import hss_pkg::*;

  cfg_t    cfg_q;
  logic    q_push, q_pop;
  job_t    front_job, queue_job;
  q_stat_t q_stat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coeff_x   <= '0;
      cfg_q.coeff_y   <= '0;
      cfg_q.rows_used <= DIM_W'(MAX_ROWS);
      cfg_q.cols_used <= DIM_W'(MAX_COLS);
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_COEFF_X:   cfg_q.coeff_x   <= cfg_data_i[COEFF_W-1:0];
        CFG_COEFF_Y:   cfg_q.coeff_y   <= cfg_data_i[COEFF_W-1:0];
        CFG_ROWS_USED: cfg_q.rows_used <= cfg_data_i[DIM_W-1:0];
        CFG_COLS_USED: cfg_q.cols_used <= cfg_data_i[DIM_W-1:0];
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  hss_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .items_i  (items_i),
    .q_stat_i (q_stat),
    .push_o   (q_push),
    .job_o    (front_job)
  );

  hss_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (front_job),
    .pop_i  (q_pop),
    .job_o  (queue_job),
    .stat_o (q_stat)
  );

  hss_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .job_i     (queue_job),
    .q_stat_i  (q_stat),
    .pop_o     (q_pop),
    .results_o (results_o)
  );

  // The front end never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_stat.full)
    else $error("job pushed into a full queue");

  // The back end never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_stat.empty)
    else $error("job popped from an empty queue");

  // The closing result of a sweep sits in the last column of an inner row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (results_o.valid && results_o.last_of_grid) |->
      ((results_o.col >= COL_W'(2)) && (results_o.row != '0)))
    else $error("end of sweep marked on a point that cannot close it");

endmodule
